/* rtl/lcd_ddram_capture_defines.svh */
// ----------------------------------------------------------------------------
// lcd_ddram_capture_defines
// assertion macros shared by the checker of the display capture block
// ----------------------------------------------------------------------------
`ifndef LCD_DDRAM_CAPTURE_DEFINES_SVH
`define LCD_DDRAM_CAPTURE_DEFINES_SVH

// same-cycle implication
`define LCDCAP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LCDCAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// implication after a fixed number of cycles
`define LCDCAP_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) else $error(msg);

`endif

/* rtl/lcdcap_pkg.sv */
// ----------------------------------------------------------------------------
// lcdcap_pkg
// types and constants of the display text capture block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcdcap_pkg;

  // request commands
  localparam logic [1:0] CMD_FRAME     = 2'd0;
  localparam logic [1:0] CMD_SET_READ  = 2'd1;
  localparam logic [1:0] CMD_READ_BYTE = 2'd2;
  localparam logic [1:0] CMD_CLEAR_SWP = 2'd3;

  localparam logic [7:0] FRAME_BYTES = 8'd6;
  localparam logic [6:0] ROW2_OFFSET = 7'd16;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

/* rtl/lcdcap_ctrl.sv */
// ----------------------------------------------------------------------------
// lcdcap_ctrl
// sequencer: capture a request, execute it, then hold the result until taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdcap_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lcdcap_pkg::dp_cmd_t cmd
);
  import lcdcap_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_DONE);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.execute = (state_r == S_EXEC);

endmodule

/* rtl/lcdcap_dp.sv */
// ----------------------------------------------------------------------------
// lcdcap_dp
// request registers, character banks, pointer and flag registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdcap_dp #(
  parameter int BANK_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcdcap_pkg::dp_cmd_t cmd,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_frame_length,
  input  logic [7:0]          in_third_byte,
  input  logic [7:0]          in_sixth_byte,
  input  logic [4:0]          in_read_index,
  input  logic                in_reading_value,
  output logic [7:0]          out_read_data,
  output logic                out_swapped_flag
);
  import lcdcap_pkg::*;

  localparam int DEPTH = 2 * BANK_BYTES;
  localparam int AW    = $clog2(DEPTH);

  // captured request
  logic [1:0] command_r;
  logic [7:0] frame_length_r;
  logic [7:0] third_byte_r;
  logic [7:0] sixth_byte_r;
  logic [4:0] read_index_r;
  logic       reading_value_r;

  // character store, entries without a valid bit read as zero
  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       rd_mem_r;
  logic             rd_ok_r;

  logic       wsel_r, wsel_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic       skip_r, skip_nxt;
  logic       reading_r, reading_nxt;
  logic       swapped_r, swapped_nxt;

  logic [7:0]    value;
  logic          rs;
  logic          frame_ok;
  logic          wr_en;
  logic          rd_hit;
  logic [AW-1:0] wr_base;
  logic [AW-1:0] rd_base;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command_r       <= in_command;
      frame_length_r  <= in_frame_length;
      third_byte_r    <= in_third_byte;
      sixth_byte_r    <= in_sixth_byte;
      read_index_r    <= in_read_index;
      reading_value_r <= in_reading_value;
    end
  end

  assign value    = {third_byte_r[7:4], sixth_byte_r[7:4]};
  assign rs       = sixth_byte_r[0];
  assign frame_ok = (command_r == CMD_FRAME) && (frame_length_r == FRAME_BYTES);
  assign wr_base  = wsel_r ? AW'(BANK_BYTES) : '0;
  assign rd_base  = wsel_r ? '0 : AW'(BANK_BYTES);
  assign waddr    = wr_base + AW'(pos_r);
  assign raddr    = rd_base + AW'(read_index_r);
  assign rd_hit   = (command_r == CMD_READ_BYTE)
                    && ({2'b00, read_index_r} < 7'(BANK_BYTES));

  always_comb begin
    wsel_nxt    = wsel_r;
    pos_nxt     = pos_r;
    skip_nxt    = skip_r;
    reading_nxt = reading_r;
    swapped_nxt = swapped_r;
    wr_en       = 1'b0;
    case (command_r)
      CMD_FRAME: begin
        if (frame_ok) begin
          if (rs) begin
            if (skip_r) begin
              skip_nxt = 1'b0;
            end else if (pos_r < 7'(BANK_BYTES)) begin
              wr_en   = 1'b1;
              pos_nxt = pos_r + 7'd1;
            end
          end else if (value[7]) begin
            if (value[6]) begin
              // second row starts at offset 16
              pos_nxt = {1'b0, value[5:0]} + ROW2_OFFSET;
            end else begin
              pos_nxt = value[6:0];
              if ((value[6:0] == 7'd0) && !reading_r) begin
                wsel_nxt    = ~wsel_r;
                swapped_nxt = 1'b1;
              end
            end
          end else if (value[6]) begin
            // character generator address: next data byte is dropped
            skip_nxt = 1'b1;
          end
        end
      end
      CMD_SET_READ:  reading_nxt = reading_value_r;
      CMD_READ_BYTE: ;
      CMD_CLEAR_SWP: swapped_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsel_r    <= 1'b1;
      pos_r     <= '0;
      skip_r    <= 1'b0;
      reading_r <= 1'b0;
      swapped_r <= 1'b0;
      vld_r     <= '0;
      rd_ok_r   <= 1'b0;
    end else if (cmd.execute) begin
      wsel_r    <= wsel_nxt;
      pos_r     <= pos_nxt;
      skip_r    <= skip_nxt;
      reading_r <= reading_nxt;
      swapped_r <= swapped_nxt;
      rd_ok_r   <= rd_hit && vld_r[raddr];
      if (wr_en) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (wr_en) begin
        mem[waddr] <= value;
      end
      rd_mem_r <= mem[raddr];
    end
  end

  assign out_read_data    = rd_ok_r ? rd_mem_r : 8'd0;
  assign out_swapped_flag = swapped_r;

endmodule

/* rtl/lcd_ddram_capture.sv */
// ----------------------------------------------------------------------------
// lcd_ddram_capture
// captures the two-row text written to a 4-bit character display via a
// port expander, in two swapping banks
// ----------------------------------------------------------------------------
// usage
//   input channel: one request per handshake; command 0 is a bus write frame
//   (only six-byte frames act), 1 sets the reading flag, 2 reads a byte of
//   the read bank, 3 clears the swapped flag
//   result channel: one result per request, read_data (zero unless a byte
//   read hits the bank) and swapped_flag as left by the request
//   order: a taken request is executed, then its result is valid in the hold
//   step; the capture, execute and hold steps of the sequencer run in turn and
//   no new request is taken until the result of the last one is taken, one
//   memory access happening in the execute step
//   reset: banks read as zero, upper half is the write bank, pointer and
//   flags cleared; no clearing pass is needed
//   stall: the result is held unchanged and no new request is taken until
//   the result has been taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_ddram_capture #(
  parameter int BANK_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_frame_length,
  input  logic [7:0] in_third_byte,
  input  logic [7:0] in_sixth_byte,
  input  logic [4:0] in_read_index,
  input  logic       in_reading_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_swapped_flag
);
  import lcdcap_pkg::*;

  dp_cmd_t cmd;

  lcdcap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lcdcap_dp #(
    .BANK_BYTES (BANK_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_command       (in_command),
    .in_frame_length  (in_frame_length),
    .in_third_byte    (in_third_byte),
    .in_sixth_byte    (in_sixth_byte),
    .in_read_index    (in_read_index),
    .in_reading_value (in_reading_value),
    .out_read_data    (out_read_data),
    .out_swapped_flag (out_swapped_flag)
  );

endmodule

/* rtl/lcdcap_check.sv */
// ----------------------------------------------------------------------------
// lcdcap_check
// port-level checks of the display capture block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lcd_ddram_capture_defines.svh"

module lcdcap_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic       out_swapped_flag
);
  import lcdcap_pkg::*;

  `LCDCAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_data) && $stable(out_swapped_flag), "stalled result changed")

  `LCDCAP_ASSERT_IMPL(a_one_at_a_time, out_valid, in_stall, "request taken while result pending")

  `LCDCAP_ASSERT_DLY(a_zero_data, in_valid && !in_stall && in_command != CMD_READ_BYTE, 2, out_valid && out_read_data == 8'd0, "non-read result carries data")

  `LCDCAP_ASSERT_DLY(a_clear_swp, in_valid && !in_stall && in_command == CMD_CLEAR_SWP, 2, out_valid && !out_swapped_flag, "swapped flag not cleared")

endmodule

bind lcd_ddram_capture lcdcap_check u_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_command       (in_command),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_read_data    (out_read_data),
  .out_swapped_flag (out_swapped_flag)
);

/* tb/sv/lcd_ddram_capture_tb.sv */
// ----------------------------------------------------------------------------
// lcd_ddram_capture_tb
// self-checking bench for the display text capture block: directed display
// sequences, then random screens of text, cursor moves, bank swaps and reads,
// all predicted by a shadow copy of both banks and the pointer state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_ddram_capture_tb;
  import lcdcap_pkg::*;

  localparam int          BANK_BYTES   = 32;
  localparam int          ITEM_TARGET  = 1750;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          HOLD_CYCLES  = 300;

  // display instruction codes as sent over the expander
  localparam logic [7:0]  LCD_SET_DDRAM  = 8'h80;
  localparam logic [7:0]  LCD_SET_CGRAM  = 8'h40;
  localparam logic [7:0]  LCD_ROW2_HOME  = 8'hC0;
  localparam logic [7:0]  LCD_FUNC_SET   = 8'h28;
  localparam logic [7:0]  LCD_LAST_ADDR  = 8'hFF;
  localparam logic        RS_COMMAND     = 1'b0;
  localparam logic        RS_DATA        = 1'b1;
  localparam int          DDRAM_BIT      = 7;
  localparam int          CGRAM_BIT      = 6;
  localparam logic [6:0]  ROW2_BASE      = 7'h40;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] frame_length;
    logic [7:0] third_byte;
    logic [7:0] sixth_byte;
    logic [4:0] read_index;
    logic       reading_value;
  } lcd_request_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       swapped_flag;
  } lcd_readback_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_command;
  logic [7:0] in_frame_length;
  logic [7:0] in_third_byte;
  logic [7:0] in_sixth_byte;
  logic [4:0] in_read_index;
  logic       in_reading_value;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_read_data;
  logic       out_swapped_flag;

  // shadow of the block state
  logic [7:0] shadow_chars [2*BANK_BYTES];
  logic       shadow_write_bank;
  logic [6:0] shadow_pos;
  logic       shadow_skip;
  logic       shadow_reading;
  logic       shadow_swapped;

  lcd_readback_t pending_readbacks [$];

  bit          send_idle;
  bit          recv_idle;
  int unsigned recv_hold;
  int unsigned cycle_count;
  int unsigned n_errors;
  int unsigned n_items;
  int unsigned n_frames;
  int unsigned n_checked;
  int unsigned n_swaps;
  int unsigned n_dropped;
  int unsigned n_skipped;

  lcd_ddram_capture #(.BANK_BYTES(BANK_BYTES)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_frame_length  (in_frame_length),
    .in_third_byte    (in_third_byte),
    .in_sixth_byte    (in_sixth_byte),
    .in_read_index    (in_read_index),
    .in_reading_value (in_reading_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_swapped_flag (out_swapped_flag)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    do @(posedge clk); while (cycle_count < CYCLE_LIMIT);
    $error("timeout after %0d cycles, %0d readbacks outstanding", cycle_count,
           pending_readbacks.size());
    $display("== FAIL ==");
    $finish;
  end

  // applies one request to the shadow state and returns the readback it causes
  function automatic lcd_readback_t apply_request(lcd_request_t req);
    lcd_readback_t res;
    logic [7:0]    value;
    logic [6:0]    addr;
    int            base;
    res.read_data = 8'h00;
    case (req.command)
      CMD_FRAME: begin
        if (req.frame_length == FRAME_BYTES) begin
          n_frames++;
          value = {req.third_byte[7:4], req.sixth_byte[7:4]};
          if (req.sixth_byte[0] == RS_DATA) begin
            base = shadow_write_bank ? BANK_BYTES : 0;
            if (shadow_skip) begin
              shadow_skip = 1'b0;
              n_skipped++;
            end else if (shadow_pos < BANK_BYTES) begin
              shadow_chars[base + shadow_pos] = value;
              shadow_pos = shadow_pos + 7'd1;
            end else begin
              n_dropped++;
            end
          end else if (value[DDRAM_BIT]) begin
            addr = value[6:0];
            if (addr >= ROW2_BASE) begin
              shadow_pos = addr - ROW2_BASE + ROW2_OFFSET;
            end else begin
              shadow_pos = addr;
              if (addr == 7'd0 && !shadow_reading) begin
                shadow_write_bank = ~shadow_write_bank;
                shadow_swapped = 1'b1;
                n_swaps++;
              end
            end
          end else if (value[CGRAM_BIT]) begin
            shadow_skip = 1'b1;
          end
        end
      end
      CMD_SET_READ: begin
        shadow_reading = req.reading_value;
      end
      CMD_READ_BYTE: begin
        base = shadow_write_bank ? 0 : BANK_BYTES;
        if (req.read_index < BANK_BYTES) res.read_data = shadow_chars[base + req.read_index];
      end
      default: begin
        shadow_swapped = 1'b0;
      end
    endcase
    res.swapped_flag = shadow_swapped;
    return res;
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [7:0] len,
                              input logic [7:0] b3, input logic [7:0] b6,
                              input logic [4:0] idx, input logic rv);
    int unsigned  gap;
    lcd_request_t req;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_frame_length  <= len;
    in_third_byte    <= b3;
    in_sixth_byte    <= b6;
    in_read_index    <= idx;
    in_reading_value <= rv;
    do @(posedge clk); while (in_stall !== 1'b0);
    req.command       = cmd;
    req.frame_length  = len;
    req.third_byte    = b3;
    req.sixth_byte    = b6;
    req.read_index    = idx;
    req.reading_value = rv;
    pending_readbacks.push_back(apply_request(req));
    n_items++;
  endtask

  // one display byte as a six-byte frame; unused nibble bits carry noise
  task automatic send_display_byte(input logic [7:0] value, input logic rs);
    logic [3:0] pad3;
    logic [2:0] pad6;
    pad3 = 4'($urandom);
    pad6 = 3'($urandom);
    send_request(CMD_FRAME, FRAME_BYTES, {value[7:4], pad3}, {value[3:0], pad6, rs},
                 5'($urandom), 1'($urandom));
  endtask

  task automatic send_command(input logic [1:0] cmd, input logic [4:0] idx, input logic rv);
    send_request(cmd, 8'($urandom), 8'($urandom), 8'($urandom), idx, rv);
  endtask

  task automatic wait_until_empty();
    in_valid <= 1'b0;
    while (pending_readbacks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stall per result, or a long hold when one is asked for
  initial begin : result_sink
    int unsigned n;
    forever begin
      if (recv_hold != 0) begin
        n = recv_hold;
        recv_hold = 0;
      end else begin
        n = recv_idle ? $urandom_range(0, 12) : 0;
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  always @(posedge clk) begin
    lcd_readback_t exp_rb;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_readbacks.size() == 0) begin
        $error("result with no request outstanding: read_data %0h swapped_flag %0b",
               out_read_data, out_swapped_flag);
        n_errors++;
      end else begin
        exp_rb = pending_readbacks.pop_front();
        n_checked++;
        if (out_read_data !== exp_rb.read_data) begin
          $error("read_data: expected %0h, got %0h", exp_rb.read_data, out_read_data);
          n_errors++;
        end
        if (out_swapped_flag !== exp_rb.swapped_flag) begin
          $error("swapped_flag: expected %0b, got %0b", exp_rb.swapped_flag,
                 out_swapped_flag);
          n_errors++;
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_command(CMD_READ_BYTE, 5'd0, 1'b0);
    send_command(CMD_READ_BYTE, 5'd31, 1'b1);
    // frames of the wrong length are ignored
    send_request(CMD_FRAME, 8'd0, 8'h40, 8'h11, 5'd0, 1'b0);
    send_request(CMD_FRAME, 8'd255, 8'h40, 8'h11, 5'd31, 1'b1);
    send_request(CMD_FRAME, 8'd5, 8'h80, 8'h00, 5'd0, 1'b0);
    send_request(CMD_FRAME, 8'd7, 8'h80, 8'h00, 5'd0, 1'b0);
    send_display_byte(8'h48, RS_DATA);
    send_display_byte(8'hFF, RS_DATA);
    send_display_byte(8'h00, RS_DATA);
    // cursor home swaps the banks
    send_display_byte(LCD_SET_DDRAM, RS_COMMAND);
    send_command(CMD_READ_BYTE, 5'd0, 1'b0);
    send_command(CMD_READ_BYTE, 5'd1, 1'b0);
    send_command(CMD_CLEAR_SWP, 5'd0, 1'b0);
    // character-generator address eats the next data byte
    send_display_byte(LCD_SET_CGRAM | 8'h3F, RS_COMMAND);
    send_display_byte(8'h55, RS_DATA);
    send_display_byte(8'h69, RS_DATA);
    // no swap while a read is in progress
    send_command(CMD_SET_READ, 5'd0, 1'b1);
    send_display_byte(LCD_SET_DDRAM, RS_COMMAND);
    send_command(CMD_READ_BYTE, 5'd0, 1'b1);
    send_command(CMD_SET_READ, 5'd0, 1'b0);
    // last cell of the bank, then one past it
    send_display_byte(LCD_SET_DDRAM | 8'h1F, RS_COMMAND);
    send_display_byte(8'h5A, RS_DATA);
    send_display_byte(8'hA5, RS_DATA);
    send_display_byte(LCD_LAST_ADDR, RS_COMMAND);
    send_display_byte(8'h3C, RS_DATA);
    send_display_byte(LCD_ROW2_HOME, RS_COMMAND);
    send_display_byte(8'h72, RS_DATA);
    send_display_byte(LCD_FUNC_SET, RS_COMMAND);
    send_display_byte(LCD_SET_DDRAM, RS_COMMAND);
    send_command(CMD_READ_BYTE, 5'd16, 1'b0);
    send_command(CMD_READ_BYTE, 5'd31, 1'b0);
    wait_until_empty();
  endtask

  task automatic random_burst();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  v;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
        send_display_byte(v, RS_DATA);
      end
    end else if (pick < 62) begin
      if ($urandom_range(0, 3) == 0) v = LCD_SET_DDRAM | 8'($urandom_range(0, 127));
      else v = ($urandom_range(0, 1) ? LCD_ROW2_HOME : LCD_SET_DDRAM) | 8'($urandom_range(0, 15));
      send_display_byte(v, RS_COMMAND);
    end else if (pick < 68) begin
      send_display_byte(LCD_SET_CGRAM | 8'($urandom_range(0, 63)), RS_COMMAND);
      send_display_byte(8'($urandom), RS_DATA);
    end else if (pick < 78) begin
      send_command(CMD_SET_READ, 5'($urandom), 1'b1);
      n = $urandom_range(1, 6);
      repeat (n) send_command(CMD_READ_BYTE, 5'($urandom), 1'($urandom));
      if ($urandom_range(0, 3) != 0) send_command(CMD_SET_READ, 5'($urandom), 1'b0);
    end else if (pick < 84) begin
      send_display_byte(LCD_SET_DDRAM, RS_COMMAND);
    end else if (pick < 88) begin
      send_command(CMD_CLEAR_SWP, 5'($urandom), 1'($urandom));
    end else if (pick < 91) begin
      send_display_byte({2'b00, 6'($urandom)}, RS_COMMAND);
    end else begin
      send_request(2'($urandom), $urandom_range(0, 1) ? FRAME_BYTES : 8'($urandom),
                   8'($urandom), 8'($urandom), 5'($urandom), 1'($urandom));
    end
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_back_pressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    recv_hold = HOLD_CYCLES;
    repeat (30) random_burst();
    wait_until_empty();
  endtask

  // sender and receiver both idle at random, then wait until every readback has come back
  task automatic test_quiet_sender();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (40) random_burst();
    wait_until_empty();
  endtask

  task automatic test_random_screens();
    int unsigned phase;
    phase = 0;
    while (n_items < ITEM_TARGET) begin
      send_idle = (phase % 4 == 0) || (phase % 4 == 2);
      recv_idle = (phase % 4 == 0) || (phase % 4 == 3);
      repeat (40) random_burst();
      phase++;
    end
    wait_until_empty();
  endtask

  initial begin
    cycle_count      = 0;
    n_errors         = 0;
    n_items          = 0;
    n_frames         = 0;
    n_checked        = 0;
    n_swaps          = 0;
    n_dropped        = 0;
    n_skipped        = 0;
    recv_hold        = 0;
    send_idle        = 1'b0;
    recv_idle        = 1'b0;
    foreach (shadow_chars[i]) shadow_chars[i] = 8'h00;
    shadow_write_bank = 1'b1;
    shadow_pos        = 7'd0;
    shadow_skip       = 1'b0;
    shadow_reading    = 1'b0;
    shadow_swapped    = 1'b0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_command       <= CMD_FRAME;
    in_frame_length  <= 8'd0;
    in_third_byte    <= 8'd0;
    in_sixth_byte    <= 8'd0;
    in_read_index    <= 5'd0;
    in_reading_value <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_back_pressure();
    test_quiet_sender();
    test_random_screens();

    $display("covered %0d requests, %0d six-byte frames, %0d readbacks checked",
             n_items, n_frames, n_checked);
    $display("bank swaps %0d, data bytes past the bank %0d, bytes skipped after cgram %0d",
             n_swaps, n_dropped, n_skipped);
    if (n_errors == 0 && pending_readbacks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
